### design/msbbf_pkg.sv
// Package for the MSB-first bit-field buffer: request and status codes,
// sequencer state type and fixed field widths.
// No dependencies; used by msb_first_bit_field_buffer_unit.
package msbbf_pkg;

  localparam int unsigned FIELD_MAX_BITS = 32;
  localparam int unsigned BYTE_BITS      = 8;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned BLEN_W  = 13;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam req_t REQ_READ   = 2'd0;
  localparam req_t REQ_WRITE  = 2'd1;
  localparam req_t REQ_REWIND = 2'd2;
  localparam req_t REQ_UNUSED = 2'd3;

  localparam stat_t STAT_DONE      = 2'd0;
  localparam stat_t STAT_WIDTH_BAD = 2'd1;
  localparam stat_t STAT_PAST_END  = 2'd2;

  // Register index taken from the word address of the configuration port.
  localparam logic [0:0] REG_IDX_BUFFER_LENGTH = 1'b0;

  localparam logic [BLEN_W-1:0] BUFFER_LENGTH_RESET = 13'd4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MOVE,
    ST_DONE
  } state_t;

endpackage

### design/msb_first_bit_field_buffer_unit.sv
// Top level of the MSB-first bit-field buffer: byte store, shared bit cursor,
// request sequencer and APB-style configuration register.
// Depends on msbbf_pkg.
//
// This block reads and writes fields of 0 to 32 bits, most significant bit
// first, packed across byte boundaries in a byte-wide store of STORE_BYTES
// entries, with one bit cursor shared by all requests. Each accepted word
// gives exactly one result word. After reset the block runs a clearing pass
// that writes zero into every byte; in_ready stays low during that pass,
// while configuration writes are taken as usual. An item then passes the
// check state, one move step for each byte the field touches (none for
// rewinds, refusals and zero width fields, up to 5 for a 32-bit field that
// starts mid-byte) and the done state before the next word is accepted.
// The walk is bounded by the single read port of the store: the sequencer
// walks one byte per cycle, merging the returned byte and issuing the read
// of the next byte in the same cycle. A write ORs its bits into the store
// through that same read-modify-write walk. Successive bytes of one field
// sit at distinct addresses, and the next item's first read is issued only
// after the previous write has landed, so no forwarding is needed. A
// finished result sits in an output register, so a new word is accepted
// while the previous result waits for out_ready. buffer_length at byte
// address 0 bounds the active store; a request whose last touched byte lies
// at or past min(buffer_length, STORE_BYTES) is refused with status 2, a
// width above 32 with status 1, and neither moves the cursor.
module msb_first_bit_field_buffer_unit #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [msbbf_pkg::REQ_W-1:0]           in_req_type,
  input  logic [msbbf_pkg::COUNT_W-1:0]         in_bit_count,
  input  logic [msbbf_pkg::VALUE_W-1:0]         in_write_value,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [msbbf_pkg::VALUE_W-1:0]         out_read_value,
  output logic [msbbf_pkg::STAT_W-1:0]          out_status,
  // Configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [msbbf_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [msbbf_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [msbbf_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                  cfg_pready
);

  // Store address width, cursor width (the cursor may rest one past the last
  // byte) and compare width for the bounds check.
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned PW = $clog2(STORE_BYTES + 1);
  localparam int unsigned CW =
    ((PW > msbbf_pkg::BLEN_W) ? PW : msbbf_pkg::BLEN_W) + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [CW-1:0] STORE_LIM = CW'(STORE_BYTES);
  localparam logic [3:0]    BYTE_B4   = 4'(msbbf_pkg::BYTE_BITS);
  localparam logic [msbbf_pkg::COUNT_W-1:0] MAX_W =
    msbbf_pkg::COUNT_W'(msbbf_pkg::FIELD_MAX_BITS);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [msbbf_pkg::BLEN_W-1:0] buf_len_r;
  logic                         cfg_sel_blen;

  assign cfg_sel_blen = (cfg_paddr[msbbf_pkg::CFG_ADDR_W-1] ==
                         msbbf_pkg::REG_IDX_BUFFER_LENGTH);
  assign cfg_pready   = 1'b1;
  assign cfg_prdata   = cfg_sel_blen ?
                        msbbf_pkg::CFG_DATA_W'(buf_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= msbbf_pkg::BUFFER_LENGTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_sel_blen) begin
      buf_len_r <= cfg_pwdata[msbbf_pkg::BLEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  msbbf_pkg::state_t               state_r, state_nxt;
  logic [AW-1:0]                   clr_addr_r;
  msbbf_pkg::req_t                 req_r;
  logic [msbbf_pkg::COUNT_W-1:0]   cnt_r;
  logic [msbbf_pkg::VALUE_W-1:0]   val_r;
  logic [msbbf_pkg::COUNT_W-1:0]   left_r;
  logic [msbbf_pkg::VALUE_W-1:0]   acc_r;
  msbbf_pkg::stat_t                stat_r;
  logic [PW-1:0]                   byte_pos_r;
  logic [2:0]                      bit_pos_r;
  logic                            out_valid_r;
  logic [msbbf_pkg::VALUE_W-1:0]   out_value_r;
  msbbf_pkg::stat_t                out_stat_r;

  // Byte store: one write port, one registered read port.
  logic [7:0]    store_mem [STORE_BYTES];
  logic [7:0]    rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // ---------------------------------------------------------------------
  // Request checks, evaluated in the check state
  // ---------------------------------------------------------------------
  logic [6:0]              span;
  logic [3:0]              touched;
  logic [CW-1:0]           end_pos;
  logic [CW-1:0]           limit;
  logic                    is_rw;
  logic                    width_bad;
  logic                    bounds_bad;
  logic                    start_move;
  msbbf_pkg::stat_t        chk_stat;

  assign span    = 7'(bit_pos_r) + 7'(cnt_r);
  assign touched = 4'(span[6:3]) + 4'(|span[2:0]);
  assign end_pos = CW'(byte_pos_r) + CW'(touched);
  assign limit   = (CW'(buf_len_r) > STORE_LIM) ? STORE_LIM : CW'(buf_len_r);

  assign is_rw      = (req_r == msbbf_pkg::REQ_READ) ||
                      (req_r == msbbf_pkg::REQ_WRITE);
  assign width_bad  = is_rw && (cnt_r > MAX_W);
  assign bounds_bad = is_rw && !width_bad && (end_pos > limit);
  assign start_move = is_rw && !width_bad && !bounds_bad && (cnt_r != '0);

  always_comb begin
    priority if (width_bad) begin
      chk_stat = msbbf_pkg::STAT_WIDTH_BAD;
    end else if (bounds_bad) begin
      chk_stat = msbbf_pkg::STAT_PAST_END;
    end else begin
      chk_stat = msbbf_pkg::STAT_DONE;
    end
  end

  // ---------------------------------------------------------------------
  // Per-byte step of the field walk
  // ---------------------------------------------------------------------
  logic [3:0]                    room;
  logic [3:0]                    take;
  logic [3:0]                    bit_sum;
  logic [3:0]                    lsb;
  logic [7:0]                    mask;
  logic [msbbf_pkg::COUNT_W-1:0] left_nxt;
  logic [7:0]                    rd_chunk;
  logic [7:0]                    wr_chunk;
  logic [msbbf_pkg::VALUE_W-1:0] acc_nxt;

  assign room     = BYTE_B4 - 4'(bit_pos_r);
  assign take     = (left_r > msbbf_pkg::COUNT_W'(room)) ? room : left_r[3:0];
  assign bit_sum  = 4'(bit_pos_r) + take;
  assign lsb      = BYTE_B4 - bit_sum;
  assign mask     = 8'((9'd1 << take) - 9'd1);
  assign left_nxt = left_r - msbbf_pkg::COUNT_W'(take);
  assign rd_chunk = (rdata_r >> lsb[2:0]) & mask;
  assign wr_chunk = 8'(val_r >> left_nxt) & mask;
  assign acc_nxt  = (acc_r << take) | msbbf_pkg::VALUE_W'(rd_chunk);

  logic out_load;

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msbbf_pkg::ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = msbbf_pkg::ST_IDLE;
        end
      end
      msbbf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = msbbf_pkg::ST_CHECK;
        end
      end
      msbbf_pkg::ST_CHECK: begin
        state_nxt = start_move ? msbbf_pkg::ST_MOVE : msbbf_pkg::ST_DONE;
      end
      msbbf_pkg::ST_MOVE: begin
        if (left_nxt == '0) begin
          state_nxt = msbbf_pkg::ST_DONE;
        end
      end
      msbbf_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = msbbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msbbf_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs to the store and the handshakes
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = byte_pos_r[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = byte_pos_r[AW-1:0];
    wr_data  = rdata_r | 8'(wr_chunk << lsb[2:0]);
    out_load = 1'b0;
    unique case (state_r)
      msbbf_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      msbbf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      msbbf_pkg::ST_CHECK: begin
        // Fetch the byte under the cursor.
        rd_en = start_move;
      end
      msbbf_pkg::ST_MOVE: begin
        // Merge the current byte and fetch the next one in the same cycle.
        wr_en   = (req_r == msbbf_pkg::REQ_WRITE);
        rd_en   = (left_nxt != '0);
        rd_addr = byte_pos_r[AW-1:0] + AW'(1);
      end
      msbbf_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Byte store
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Control and cursor registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= msbbf_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      byte_pos_r <= '0;
      bit_pos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == msbbf_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == msbbf_pkg::ST_CHECK &&
          req_r == msbbf_pkg::REQ_REWIND) begin
        byte_pos_r <= '0;
        bit_pos_r  <= '0;
      end else if (state_r == msbbf_pkg::ST_MOVE) begin
        if (bit_sum[3]) begin
          bit_pos_r  <= '0;
          byte_pos_r <= byte_pos_r + PW'(1);
        end else begin
          bit_pos_r <= bit_sum[2:0];
        end
      end
    end
  end

  // Request and walk payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      cnt_r <= in_bit_count;
      val_r <= in_write_value;
    end
    if (state_r == msbbf_pkg::ST_CHECK) begin
      left_r <= cnt_r;
      acc_r  <= '0;
      stat_r <= chk_stat;
    end else if (state_r == msbbf_pkg::ST_MOVE) begin
      left_r <= left_nxt;
      if (req_r == msbbf_pkg::REQ_READ) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= acc_r;
      out_stat_r  <= stat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_stat_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("store read and write hit the same byte in one cycle");

  a_move_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msbbf_pkg::ST_MOVE) |-> (left_r != '0))
    else $error("field walk running with no bits left");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == msbbf_pkg::ST_CLEAR) ||
               (req_r == msbbf_pkg::REQ_WRITE)))
    else $error("store written outside a clear or a field write");

  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != msbbf_pkg::STAT_DONE)) |->
      (out_value_r == '0))
    else $error("refused request returned a nonzero value");

  a_cursor_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (PW + 1)'(byte_pos_r) <= (PW + 1)'(STORE_BYTES))
    else $error("cursor moved past the end of the store");

endmodule
